// ----- rtl/tpb_pkg.sv -----
// ---------------------------------------------------------------------------
// tpb_pkg: shared definitions of the turtle plotter
// Command codes, field widths, headings and the control groups passed
// between the command sequencer and the row marker.
// ---------------------------------------------------------------------------
package tpb_pkg;

   // field widths fixed by the item format
   localparam int OP_W    = 3;
   localparam int DIST_W  = 5;
   localparam int COORD_W = 5;
   localparam int HEAD_W  = 2;

   // default map size
   localparam int GRID_WIDTH_DEFAULT  = 32;
   localparam int GRID_HEIGHT_DEFAULT = 32;

   // command codes
   localparam logic [OP_W-1:0] OP_PEN_UP     = 3'd0;
   localparam logic [OP_W-1:0] OP_PEN_DOWN   = 3'd1;
   localparam logic [OP_W-1:0] OP_TURN_RIGHT = 3'd2;
   localparam logic [OP_W-1:0] OP_TURN_LEFT  = 3'd3;
   localparam logic [OP_W-1:0] OP_MOVE       = 3'd4;
   localparam logic [OP_W-1:0] OP_READ       = 3'd5;

   // headings
   localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd2;
   localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd3;

   // status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // requests from the sequencer to the row marker
   typedef struct packed {
      logic start;      // begin a run of read-modify-write passes
      logic probe;      // plain read of one row
      logic step_down;  // walk towards higher row numbers
   } mark_ctrl_type;

   // state reported back by the row marker
   typedef struct packed {
      logic busy;
   } mark_stat_type;

   // one result item
   typedef struct packed {
      logic               status;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [HEAD_W-1:0]  heading;
      logic               pen_down;
      logic               cell_value;
      logic               turtle_here;
   } rsp_item_type;

endpackage

// ----- rtl/tpb_if.sv -----
// ---------------------------------------------------------------------------
// tpb_if: command and result channels of the turtle plotter
// Valid/ready channels; an item moves on a rising edge with both high.
// ---------------------------------------------------------------------------
interface tpb_req_if;
   logic                         valid;
   logic                         ready;
   logic [tpb_pkg::OP_W-1:0]     operation;
   logic [tpb_pkg::DIST_W-1:0]   distance;
   logic [tpb_pkg::COORD_W-1:0]  row;
   logic [tpb_pkg::COORD_W-1:0]  column;

   modport source (output valid, operation, distance, row, column, input ready);
   modport sink   (input valid, operation, distance, row, column, output ready);
endinterface

interface tpb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [tpb_pkg::COORD_W-1:0]  pos_x;
   logic [tpb_pkg::COORD_W-1:0]  pos_y;
   logic [tpb_pkg::HEAD_W-1:0]   heading;
   logic                         pen_down;
   logic                         cell_value;
   logic                         turtle_here;

   modport source (output valid, status, pos_x, pos_y, heading, pen_down,
                   cell_value, turtle_here, input ready);
   modport sink   (input valid, status, pos_x, pos_y, heading, pen_down,
                   cell_value, turtle_here, output ready);
endinterface

// ----- rtl/tpb_ram.sv -----
// ---------------------------------------------------------------------------
// tpb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tpb_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tpb_row_marker.sv -----
// ---------------------------------------------------------------------------
// tpb_row_marker: bit map store and read-modify-write engine
// Holds the map rows in RAM with a valid bit per row, so that a row never
// written reads as clear. Marks a mask into a run of consecutive rows,
// one row per cycle, reads overlapped with the write of the row before.
// ---------------------------------------------------------------------------
module tpb_row_marker #(
   parameter int GRID_WIDTH  = tpb_pkg::GRID_WIDTH_DEFAULT,
   parameter int GRID_HEIGHT = tpb_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tpb_pkg::mark_ctrl_type         ctrl,
   input  logic [$clog2(GRID_HEIGHT)-1:0] row,
   input  logic [tpb_pkg::DIST_W-1:0]     count,
   input  logic [GRID_WIDTH-1:0]          mask,
   output tpb_pkg::mark_stat_type         stat,
   output logic [GRID_WIDTH-1:0]          row_data
);

   localparam int Y_W = $clog2(GRID_HEIGHT);

   logic [Y_W-1:0]             cur_row_ff, cur_row_in;
   logic [tpb_pkg::DIST_W-1:0] left_ff, left_in;
   logic                       down_ff, down_in;
   logic [GRID_WIDTH-1:0]      mask_ff, mask_in;
   logic                       wr_pend_ff, wr_pend_in;
   logic [Y_W-1:0]             wr_row_ff, wr_row_in;
   logic [GRID_HEIGHT-1:0]     row_valid_ff, row_valid_in;
   logic                       rd_valid_ff, rd_valid_in;

   logic                       rd_en;
   logic [Y_W-1:0]             rd_addr;
   logic [GRID_WIDTH-1:0]      rd_data;

   // read: a probe, or the next row of a run
   assign rd_en   = ctrl.probe || (left_ff != '0);
   assign rd_addr = ctrl.probe ? row : cur_row_ff;

   always_comb begin
      cur_row_in   = cur_row_ff;
      left_in      = left_ff;
      down_in      = down_ff;
      mask_in      = mask_ff;
      wr_pend_in   = 1'b0;
      wr_row_in    = wr_row_ff;
      row_valid_in = row_valid_ff;
      rd_valid_in  = rd_valid_ff;

      if (rd_en) begin
         rd_valid_in = row_valid_ff[rd_addr];
      end

      if (ctrl.start) begin
         cur_row_in = row;
         left_in    = count;
         down_in    = ctrl.step_down;
         mask_in    = mask;
      end else if (left_ff != '0) begin
         // advance to the next row and queue the write-back of this one
         cur_row_in = down_ff ? cur_row_ff + Y_W'(1) : cur_row_ff - Y_W'(1);
         left_in    = left_ff - tpb_pkg::DIST_W'(1);
         wr_pend_in = 1'b1;
         wr_row_in  = cur_row_ff;
      end

      if (wr_pend_ff) begin
         row_valid_in[wr_row_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         left_ff      <= left_in;
         wr_pend_ff   <= wr_pend_in;
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
      cur_row_ff <= cur_row_in;
      down_ff    <= down_in;
      mask_ff    <= mask_in;
      wr_row_ff  <= wr_row_in;
   end

   // a row never written reads as clear
   assign row_data  = rd_valid_ff ? rd_data : '0;
   assign stat.busy = (left_ff != '0) || wr_pend_ff;

   tpb_ram #(
      .DATA_W (GRID_WIDTH),
      .DEPTH  (GRID_HEIGHT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_row_ff),
      .wr_data (row_data | mask_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/turtle_plotter_bitmap_unit.sv -----
// ---------------------------------------------------------------------------
// turtle_plotter_bitmap_unit: turtle plotter over a bit map
// Takes one command item per request and returns one result item.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries commands (pen up/down, turn right/left, move, read
//   cell); rsp_chan returns one result item per command with the turtle
//   position, heading, pen state, status and, for a read, the cell bit.
//   From acceptance, the result of a pen, turn, unknown or refused move
//   command or of a move with the pen up goes to the result register and
//   then the output register; a read passes a fetch state first, and a
//   move of n cells with the pen down passes the mark state (a horizontal
//   move counts as one row, n = 1). The map RAM sets the pace: each row
//   marked needs a read and a write-back, one row a cycle, and the RAM
//   read data is registered. Commands are taken one at a time; the next
//   is accepted as soon as the previous result has moved to the output
//   register.
//   Reset clears the turtle to the top-left corner facing east with the
//   pen up, and clears the map at once through per-row valid bits.
//   When the receiver stalls, the result is held in the output register
//   and the block finishes at most one further command, then waits.
// ---------------------------------------------------------------------------
module turtle_plotter_bitmap_unit #(
   parameter int GRID_WIDTH  = tpb_pkg::GRID_WIDTH_DEFAULT,
   parameter int GRID_HEIGHT = tpb_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tpb_req_if.sink    req_chan,
   tpb_rsp_if.source  rsp_chan
);

   localparam int X_W = $clog2(GRID_WIDTH);
   localparam int Y_W = $clog2(GRID_HEIGHT);
   // arithmetic widths: room for coordinate plus distance, and for the size
   localparam int XS  = ((X_W > tpb_pkg::COORD_W) ? X_W : tpb_pkg::COORD_W) + 1;
   localparam int YS  = ((Y_W > tpb_pkg::COORD_W) ? Y_W : tpb_pkg::COORD_W) + 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MARK   = 4'b0010,
      ST_FETCH  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;

   // turtle state
   logic [X_W-1:0]              x_ff, x_in;
   logic [Y_W-1:0]              y_ff, y_in;
   logic [tpb_pkg::HEAD_W-1:0]  head_ff, head_in;
   logic                        pen_ff, pen_in;

   // pending result and output register
   tpb_pkg::rsp_item_type  res_ff, res_in;
   tpb_pkg::rsp_item_type  out_ff, out_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // read command context
   logic                   rd_in_range_ff, rd_in_range_in;
   logic [X_W-1:0]         rd_col_ff, rd_col_in;

   // row marker link
   tpb_pkg::mark_ctrl_type      mk_ctrl;
   tpb_pkg::mark_stat_type      mk_stat;
   logic [Y_W-1:0]              mk_row;
   logic [tpb_pkg::DIST_W-1:0]  mk_count;
   logic [GRID_WIDTH-1:0]       mk_mask;
   logic [GRID_WIDTH-1:0]       mk_row_data;

   logic                   accept;
   logic                   out_free;

   // widened operands
   logic [XS-1:0]          x_ext, nx_ext, x_sum, x_dif, x_lo_w, col_ext, x_out_w;
   logic [YS-1:0]          y_ext, ny_ext, y_sum, y_dif, row_ext, y_out_w;
   logic [X_W-1:0]         col_idx, mask_lo;
   logic [Y_W-1:0]         row_idx;
   logic [GRID_WIDTH-1:0]  run_ones;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign x_ext   = XS'(x_ff);
   assign y_ext   = YS'(y_ff);
   assign nx_ext  = XS'(req_chan.distance);
   assign ny_ext  = YS'(req_chan.distance);
   assign x_sum   = x_ext + nx_ext;
   assign x_dif   = x_ext - nx_ext;
   assign y_sum   = y_ext + ny_ext;
   assign y_dif   = y_ext - ny_ext;
   assign col_ext = XS'(req_chan.column);
   assign row_ext = YS'(req_chan.row);
   assign col_idx = col_ext[X_W-1:0];
   assign row_idx = row_ext[Y_W-1:0];

   // horizontal run: distance cells starting at the low end of the span
   assign run_ones = ~({GRID_WIDTH{1'b1}} << req_chan.distance);
   assign x_lo_w   = x_dif + XS'(1);
   assign mask_lo  = (head_ff == tpb_pkg::HEAD_EAST) ? x_ff : x_lo_w[X_W-1:0];

   always_comb begin
      state_in       = state_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      head_in        = head_ff;
      pen_in         = pen_ff;
      res_in         = res_ff;
      out_in         = out_ff;
      rsp_valid_in   = rsp_valid_ff;
      rd_in_range_in = rd_in_range_ff;
      rd_col_in      = rd_col_ff;
      mk_ctrl        = '0;
      mk_row         = y_ff;
      mk_count       = req_chan.distance;
      mk_mask        = GRID_WIDTH'(1) << x_ff;
      x_out_w        = '0;
      y_out_w        = '0;

      // drop the output once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in.status      = tpb_pkg::STATUS_OK;
               res_in.cell_value  = 1'b0;
               res_in.turtle_here = 1'b0;
               state_in           = ST_FINISH;
               case (req_chan.operation)
                  tpb_pkg::OP_PEN_UP:     pen_in  = 1'b0;
                  tpb_pkg::OP_PEN_DOWN:   pen_in  = 1'b1;
                  tpb_pkg::OP_TURN_RIGHT: head_in = head_ff + tpb_pkg::HEAD_W'(1);
                  tpb_pkg::OP_TURN_LEFT:  head_in = head_ff - tpb_pkg::HEAD_W'(1);
                  tpb_pkg::OP_MOVE: begin
                     // check against the map edge, then update and mark
                     case (head_ff)
                        tpb_pkg::HEAD_EAST: begin
                           if (x_sum >= XS'(GRID_WIDTH)) begin
                              res_in.status = tpb_pkg::STATUS_REFUSED;
                           end else begin
                              x_in = x_sum[X_W-1:0];
                           end
                        end
                        tpb_pkg::HEAD_WEST: begin
                           if (nx_ext > x_ext) begin
                              res_in.status = tpb_pkg::STATUS_REFUSED;
                           end else begin
                              x_in = x_dif[X_W-1:0];
                           end
                        end
                        tpb_pkg::HEAD_SOUTH: begin
                           if (y_sum >= YS'(GRID_HEIGHT)) begin
                              res_in.status = tpb_pkg::STATUS_REFUSED;
                           end else begin
                              y_in = y_sum[Y_W-1:0];
                           end
                        end
                        default: begin
                           if (ny_ext > y_ext) begin
                              res_in.status = tpb_pkg::STATUS_REFUSED;
                           end else begin
                              y_in = y_dif[Y_W-1:0];
                           end
                        end
                     endcase
                     if (head_ff == tpb_pkg::HEAD_EAST || head_ff == tpb_pkg::HEAD_WEST) begin
                        mk_count = tpb_pkg::DIST_W'(1);
                        mk_mask  = run_ones << mask_lo;
                     end
                     mk_ctrl.step_down = (head_ff == tpb_pkg::HEAD_SOUTH);
                     if (res_in.status == tpb_pkg::STATUS_OK && pen_ff &&
                         req_chan.distance != '0) begin
                        mk_ctrl.start = 1'b1;
                        state_in      = ST_MARK;
                     end
                  end
                  tpb_pkg::OP_READ: begin
                     rd_in_range_in = (row_ext < YS'(GRID_HEIGHT)) &&
                                      (col_ext < XS'(GRID_WIDTH));
                     rd_col_in      = col_idx;
                     mk_row         = row_idx;
                     mk_ctrl.probe  = rd_in_range_in;
                     res_in.turtle_here = rd_in_range_in && (row_idx == y_ff) &&
                                          (col_idx == x_ff);
                     state_in       = ST_FETCH;
                  end
                  default: ;
               endcase
               x_out_w         = XS'(x_in);
               y_out_w         = YS'(y_in);
               res_in.pos_x    = x_out_w[tpb_pkg::COORD_W-1:0];
               res_in.pos_y    = y_out_w[tpb_pkg::COORD_W-1:0];
               res_in.heading  = head_in;
               res_in.pen_down = pen_in;
            end
         end
         ST_MARK: begin
            // hold until the last row is written back
            if (!mk_stat.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FETCH: begin
            res_in.cell_value = rd_in_range_ff && mk_row_data[rd_col_ff];
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= tpb_pkg::HEAD_EAST;
         pen_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         head_ff      <= head_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff         <= res_in;
      out_ff         <= out_in;
      rd_in_range_ff <= rd_in_range_in;
      rd_col_ff      <= rd_col_in;
   end

   tpb_row_marker #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_row_marker (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mk_ctrl),
      .row      (mk_row),
      .count    (mk_count),
      .mask     (mk_mask),
      .stat     (mk_stat),
      .row_data (mk_row_data)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.pos_x       = out_ff.pos_x;
   assign rsp_chan.pos_y       = out_ff.pos_y;
   assign rsp_chan.heading     = out_ff.heading;
   assign rsp_chan.pen_down    = out_ff.pen_down;
   assign rsp_chan.cell_value  = out_ff.cell_value;
   assign rsp_chan.turtle_here = out_ff.turtle_here;

endmodule
